@@ rtl/uirb_pkg.sv @@
package uirb_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_TX_READY = 2'd2,
    CMD_RX_BYTE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_TX_DROPPED = 3'd1,
    ST_READ_OK    = 3'd2,
    ST_RX_EMPTY   = 3'd3,
    ST_SENT       = 3'd4,
    ST_TX_IDLE    = 3'd5,
    ST_RX_DROPPED = 3'd6,
    ST_IGNORED    = 3'd7
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] byte_out;
    logic       notify;
    logic       tx_irq_enabled;
  } result_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ rtl/uirb_ctrl.sv @@
module uirb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output uirb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  assign cmd.load = item_valid && item_ready;
  assign cmd.exec = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      item_ready   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid && item_ready) begin
            state      <= S_EXEC;
            item_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state        <= S_RESP;
          result_valid <= 1'b1;
        end
        S_RESP: begin
          if (result_ready) begin
            state        <= S_IDLE;
            result_valid <= 1'b0;
            item_ready   <= 1'b1;
          end
        end
        default: begin
          state        <= S_IDLE;
          item_ready   <= 1'b1;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/uirb_datapath.sv @@
module uirb_datapath #(
  parameter int TX_DEPTH = 1024,
  parameter int RX_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  uirb_pkg::ctrl_cmd_t cmd,
  input  uirb_pkg::item_t     item,
  input  logic                notify_enable,
  output uirb_pkg::result_t   result
);

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  uirb_pkg::item_t cur;

  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic             tx_busy, tx_busy_next;
  logic             tx_irq_en, tx_irq_en_next;
  logic             burst_dropping, burst_dropping_next;

  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;

  logic tx_wr, tx_rd, rx_wr, rx_rd;
  logic notify_next;
  uirb_pkg::status_t status_next;

  logic [7:0]        tx_rd_data, rx_rd_data;
  logic              sel_tx, sel_rx;
  uirb_pkg::status_t res_status;
  logic              res_notify;

  assign tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
  assign rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;

  always_comb begin
    tx_head_next        = tx_head;
    tx_tail_next        = tx_tail;
    rx_head_next        = rx_head;
    rx_tail_next        = rx_tail;
    tx_busy_next        = tx_busy;
    tx_irq_en_next      = tx_irq_en;
    burst_dropping_next = burst_dropping;
    tx_wr               = 1'b0;
    tx_rd               = 1'b0;
    rx_wr               = 1'b0;
    rx_rd               = 1'b0;
    notify_next         = 1'b0;
    status_next         = uirb_pkg::ST_IGNORED;
    case (cur.cmd)
      uirb_pkg::CMD_WRITE: begin
        status_next = uirb_pkg::ST_TX_DROPPED;
        if (burst_dropping) begin
          if (cur.last) burst_dropping_next = 1'b0;
        end else if (tx_head_inc == tx_tail) begin
          if (!cur.last) burst_dropping_next = 1'b1;
        end else begin
          tx_wr        = 1'b1;
          tx_head_next = tx_head_inc;
          status_next  = uirb_pkg::ST_QUEUED;
          if (cur.last && !tx_busy) begin
            tx_busy_next   = 1'b1;
            tx_irq_en_next = 1'b1;
          end
        end
      end
      uirb_pkg::CMD_READ: begin
        if (rx_head == rx_tail) begin
          status_next = uirb_pkg::ST_RX_EMPTY;
        end else begin
          rx_rd        = 1'b1;
          rx_tail_next = rx_tail_inc;
          status_next  = uirb_pkg::ST_READ_OK;
        end
      end
      uirb_pkg::CMD_TX_READY: begin
        if (!tx_irq_en) begin
          status_next = uirb_pkg::ST_IGNORED;
        end else if (tx_tail != tx_head) begin
          tx_rd        = 1'b1;
          tx_tail_next = tx_tail_inc;
          status_next  = uirb_pkg::ST_SENT;
        end else begin
          tx_irq_en_next = 1'b0;
          tx_busy_next   = 1'b0;
          status_next    = uirb_pkg::ST_TX_IDLE;
        end
      end
      uirb_pkg::CMD_RX_BYTE: begin
        if (rx_head_inc == rx_tail) begin
          status_next = uirb_pkg::ST_RX_DROPPED;
        end else begin
          rx_wr        = 1'b1;
          rx_head_next = rx_head_inc;
          status_next  = uirb_pkg::ST_QUEUED;
          notify_next  = notify_enable;
        end
      end
      default: begin
        status_next = uirb_pkg::ST_IGNORED;
      end
    endcase
  end

  // Hold the item being worked on
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head        <= '0;
      tx_tail        <= '0;
      rx_head        <= '0;
      rx_tail        <= '0;
      tx_busy        <= 1'b0;
      tx_irq_en      <= 1'b0;
      burst_dropping <= 1'b0;
      sel_tx         <= 1'b0;
      sel_rx         <= 1'b0;
      res_status     <= uirb_pkg::ST_IGNORED;
      res_notify     <= 1'b0;
    end else if (cmd.exec) begin
      tx_head        <= tx_head_next;
      tx_tail        <= tx_tail_next;
      rx_head        <= rx_head_next;
      rx_tail        <= rx_tail_next;
      tx_busy        <= tx_busy_next;
      tx_irq_en      <= tx_irq_en_next;
      burst_dropping <= burst_dropping_next;
      sel_tx         <= tx_rd;
      sel_rx         <= rx_rd;
      res_status     <= status_next;
      res_notify     <= notify_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tx_wr) begin
      tx_mem[tx_head] <= cur.data;
    end
    if (cmd.exec && tx_rd) begin
      tx_rd_data <= tx_mem[tx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rx_wr) begin
      rx_mem[rx_head] <= cur.data;
    end
    if (cmd.exec && rx_rd) begin
      rx_rd_data <= rx_mem[rx_tail];
    end
  end

  assign result.status         = res_status;
  assign result.byte_out       = sel_tx ? tx_rd_data : (sel_rx ? rx_rd_data : 8'd0);
  assign result.notify         = res_notify;
  assign result.tx_irq_enabled = tx_irq_en;

endmodule

@@ rtl/uart_interrupt_ring_buffers.sv @@
// Each item is captured on its transfer and executed in S_EXEC; its result is
// then offered in S_RESP and held until result_ready takes it.
// A new item is accepted only after the previous result has been taken;
// the controller works one item at a time through accept, execute, respond.
// Reset (synchronous, rst high) clears queue pointers, busy, interrupt enable,
// burst-drop state and notify_enable; queue storage is not cleared.
module uart_interrupt_ring_buffers #(
  parameter int TX_DEPTH = 1024,
  parameter int RX_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  // Item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  uirb_pkg::item_t   item,
  // Result channel
  output logic              result_valid,
  input  logic              result_ready,
  output uirb_pkg::result_t result,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  uirb_pkg::ctrl_cmd_t ctrl_cmd;
  logic                notify_enable;
  logic                reg_hit;

  // Only one register: notify_enable, decoded at byte addresses 0 to 3 (paddr[2] low).
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'd0, notify_enable} : 32'd0;

  // Take the register write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      notify_enable <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      notify_enable <= pwdata[0];
    end
  end

  // Controller sequences each item: capture, execute, present result.
  uirb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (ctrl_cmd)
  );

  // Datapath holds both ring buffers, their pointers and the flags.
  uirb_datapath #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .item          (item),
    .notify_enable (notify_enable),
    .result        (result)
  );

endmodule
